/* rtl/jddm_pkg.sv */
// Shared types and constants for the joystick differential drive mixer.
// No dependencies; jddm_front, jddm_fifo, jddm_isqrt, jddm_back and the top import this package.
`timescale 1ns / 1ps

package jddm_pkg;

    // result action codes
    typedef enum logic [1:0] {
        ACT_DRIVE = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_HOLD  = 2'd2
    } t_action;

    // sonar codes
    localparam logic [1:0] SONAR_CLEAR  = 2'd0;
    localparam logic [1:0] SONAR_OBST   = 2'd1;
    localparam logic [1:0] SONAR_CLEAR2 = 2'd2;
    localparam logic [1:0] SONAR_OTHER  = 2'd3;

    localparam int JOY_W   = 8;
    localparam int SQ_W    = 15;   // x*x, y*y of an 8-bit signed value
    localparam int DSQ_W   = 16;   // (x +/- 100)^2
    localparam int R2_W    = 16;
    localparam int A_W     = 17;
    localparam int RAD_W   = 32;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int DUTY_W  = 8;

    localparam logic signed [JOY_W:0]  JOY_OFFSET   = 9'sd100;
    localparam logic [DUTY_W-1:0]      DUTY_MAX     = 8'd255;
    localparam logic [ROOT_W-1:0]      DUTY_DIVISOR = 16'd78;
    // floor(2^16 / 78); the result is at most one short and gets one correction
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 10;
    localparam logic [RECIP_W-1:0]     DUTY_RECIP   = 10'd840;
    localparam int PROD_W      = ROOT_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;
    // root at or above 256*78 saturates the duty
    localparam logic [ROOT_W-1:0]      SAT_ROOT     = 16'd19968;

    typedef struct packed {
        logic signed [JOY_W-1:0] joy_x;
        logic signed [JOY_W-1:0] joy_y;
        t_action                 action;
        logic                    forward;
    } t_item;

    typedef struct packed {
        logic    valid;
        t_action action;
        logic    forward;
    } t_meta;

endpackage

/* rtl/jddm_in_if.sv */
// Input channel of the mixer: joystick sample and obstacle codes.
// Uses no package.
`timescale 1ns / 1ps

interface jddm_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] joy_x;
    logic signed [7:0] joy_y;
    logic              ir_obstacle;
    logic [1:0]        sonar_code;

    modport source (output valid, joy_x, joy_y, ir_obstacle, sonar_code, input ready);
    modport sink   (input valid, joy_x, joy_y, ir_obstacle, sonar_code, output ready);
endinterface

/* rtl/jddm_out_if.sv */
// Output channel of the mixer: action, wheel duties and direction.
// Uses no package.
`timescale 1ns / 1ps

interface jddm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] duty_left;
    logic [7:0] duty_right;
    logic       forward;

    modport source (output valid, action, duty_left, duty_right, forward, input ready);
    modport sink   (input valid, action, duty_left, duty_right, forward, output ready);
endinterface

/* rtl/jddm_front.sv */
// Front end: accepts input items and classifies them into drive, stop or hold.
// Depends on jddm_pkg and jddm_in_if.
`timescale 1ns / 1ps

module jddm_front (
    jddm_in_if.sink         i_in,
    input  logic            i_queue_full,
    output logic            o_wr_en,
    output jddm_pkg::t_item o_wr_item
);
    import jddm_pkg::*;

    logic       gate;
    logic       ir_g;
    logic [1:0] sonar_g;
    t_action    action;

    // obstacle codes only count while the stick points forward
    assign gate    = !i_in.joy_y[JOY_W-1] && (i_in.joy_y != '0);
    assign ir_g    = gate & i_in.ir_obstacle;
    assign sonar_g = gate ? i_in.sonar_code : SONAR_CLEAR;

    always_comb begin
        if (!ir_g && (sonar_g == SONAR_CLEAR || sonar_g == SONAR_CLEAR2)) begin
            action = ACT_DRIVE;
        end else if (ir_g || sonar_g == SONAR_OBST) begin
            action = ACT_STOP;
        end else begin
            action = ACT_HOLD;
        end
    end

    assign i_in.ready        = !i_queue_full;
    assign o_wr_en           = i_in.valid && !i_queue_full;
    assign o_wr_item.joy_x   = i_in.joy_x;
    assign o_wr_item.joy_y   = i_in.joy_y;
    assign o_wr_item.action  = action;
    assign o_wr_item.forward = gate;

endmodule

/* rtl/jddm_fifo.sv */
// Short queue between front and back; registered read data, popped on i_ce.
// Depends on jddm_pkg.
`timescale 1ns / 1ps

module jddm_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  jddm_pkg::t_item i_wr_item,
    output logic            o_full,
    input  logic            i_ce,
    output logic            o_rd_valid,
    output jddm_pkg::t_item o_rd_item
);
    import jddm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_rd_valid;
    t_item            r_rd_item;
    logic             pop;
    logic             empty;

    assign empty  = (r_count == '0);
    assign o_full = (r_count == CNT_W'(DEPTH));
    assign pop    = i_ce && !empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_wr_en, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            if (i_ce) begin
                r_rd_valid <= !empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[r_wr_ptr] <= i_wr_item;
        end
        if (pop) begin
            r_rd_item <= mem[r_rd_ptr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_item  = r_rd_item;

endmodule

/* rtl/jddm_isqrt.sv */
// Pipelined integer square root (floor), one result bit per stage, stalled by i_ce.
// Depends on jddm_pkg.
`timescale 1ns / 1ps

module jddm_isqrt (
    input  logic                        i_clk,
    input  logic                        i_ce,
    input  logic [jddm_pkg::RAD_W-1:0]  i_radicand,
    output logic [jddm_pkg::ROOT_W-1:0] o_root
);
    import jddm_pkg::*;

    logic [REM_W-1:0]  r_rem  [ROOT_W-1];
    logic [RAD_W-1:0]  r_rad  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [RAD_W-1:0]  rad_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              take;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign rad_in  = i_radicand;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign rad_in  = r_rad[g-1];
            assign root_in = r_root[g-1];
        end

        // remainder is at most 2*root, so its top two bits are free here
        assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_root[g] <= {root_in[ROOT_W-2:0], take};
            end
        end

        if (g < ROOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[g] <= take ? rem_sh - trial : rem_sh;
                    r_rad[g] <= {rad_in[RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

/* rtl/jddm_back.sv */
// Back end: squares, products, two square roots, divide by 78 and the output register.
// Depends on jddm_pkg, jddm_out_if and jddm_isqrt.
`timescale 1ns / 1ps

module jddm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  jddm_pkg::t_item i_item,
    output logic            o_ce,
    jddm_out_if.source      o_out
);
    import jddm_pkg::*;

    logic ce;

    // stage 1: squares
    t_meta             r_m1;
    logic [SQ_W-1:0]   r_sq_x, r_sq_y;
    logic [DSQ_W-1:0]  r_sq_dr, r_sq_dl;
    // stage 2: sums
    t_meta             r_m2;
    logic [R2_W-1:0]   r_r2;
    logic [A_W-1:0]    r_a_r, r_a_l;
    // stage 3: radicands
    t_meta             r_m3;
    logic [RAD_W-1:0]  r_prod_r, r_prod_l;
    // square root stages
    t_meta             r_msq [ROOT_W];
    logic [ROOT_W-1:0] root_r, root_l;
    // divide stage
    t_meta             r_md;
    logic [ROOT_W-1:0] r_root_r, r_root_l;
    logic [PROD_W-1:0] r_p_r, r_p_l;
    logic              r_sat_r, r_sat_l;
    // output register
    logic              r_out_valid;
    t_action           r_out_action;
    logic [DUTY_W-1:0] r_out_dl, r_out_dr;
    logic              r_out_fwd;

    logic signed [JOY_W:0]       dx_r, dx_l;
    logic signed [2*JOY_W-1:0]   px, py;
    logic signed [2*JOY_W+1:0]   pdr, pdl;
    logic [DUTY_W-1:0]           duty_r, duty_l;
    t_meta                       m0;

    assign ce   = !r_out_valid || o_out.ready;
    assign o_ce = ce;

    assign m0.valid   = i_valid;
    assign m0.action  = i_item.action;
    assign m0.forward = i_item.forward;

    assign dx_r = $signed({i_item.joy_x[JOY_W-1], i_item.joy_x}) - JOY_OFFSET;
    assign dx_l = $signed({i_item.joy_x[JOY_W-1], i_item.joy_x}) + JOY_OFFSET;
    assign px   = i_item.joy_x * i_item.joy_x;
    assign py   = i_item.joy_y * i_item.joy_y;
    assign pdr  = dx_r * dx_r;
    assign pdl  = dx_l * dx_l;

    // quotient estimate is at most one short of floor(root/78)
    function automatic logic [DUTY_W-1:0] duty_of(input logic [ROOT_W-1:0] root,
                                                  input logic [PROD_W-1:0] p,
                                                  input logic sat);
        logic [QUO_W-1:0]  q0;
        logic [ROOT_W-1:0] rem;
        logic [QUO_W-1:0]  q;
        q0  = p[PROD_W-1:RECIP_SHIFT];
        rem = root - ROOT_W'(q0 * DUTY_DIVISOR);
        q   = (rem >= DUTY_DIVISOR) ? q0 + 1'b1 : q0;
        return sat ? DUTY_MAX : q[DUTY_W-1:0];
    endfunction

    assign duty_r = duty_of(r_root_r, r_p_r, r_sat_r);
    assign duty_l = duty_of(r_root_l, r_p_l, r_sat_l);

    jddm_isqrt u_isqrt_r (
        .i_clk      (i_clk),
        .i_ce       (ce),
        .i_radicand (r_prod_r),
        .o_root     (root_r)
    );

    jddm_isqrt u_isqrt_l (
        .i_clk      (i_clk),
        .i_ce       (ce),
        .i_radicand (r_prod_l),
        .o_root     (root_l)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1.valid  <= 1'b0;
            r_m2.valid  <= 1'b0;
            r_m3.valid  <= 1'b0;
            r_md.valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ROOT_W; i++) begin
                r_msq[i].valid <= 1'b0;
            end
        end else if (ce) begin
            r_m1.valid  <= m0.valid;
            r_m2.valid  <= r_m1.valid;
            r_m3.valid  <= r_m2.valid;
            r_msq[0].valid <= r_m3.valid;
            for (int i = 1; i < ROOT_W; i++) begin
                r_msq[i].valid <= r_msq[i-1].valid;
            end
            r_md.valid  <= r_msq[ROOT_W-1].valid;
            r_out_valid <= r_md.valid;

            r_m1.action  <= m0.action;
            r_m1.forward <= m0.forward;
            r_sq_x       <= px[SQ_W-1:0];
            r_sq_y       <= py[SQ_W-1:0];
            r_sq_dr      <= pdr[DSQ_W-1:0];
            r_sq_dl      <= pdl[DSQ_W-1:0];

            r_m2.action  <= r_m1.action;
            r_m2.forward <= r_m1.forward;
            r_r2         <= R2_W'(r_sq_x) + R2_W'(r_sq_y);
            r_a_r        <= A_W'(r_sq_dr) + A_W'(r_sq_y);
            r_a_l        <= A_W'(r_sq_dl) + A_W'(r_sq_y);

            r_m3.action  <= r_m2.action;
            r_m3.forward <= r_m2.forward;
            r_prod_r     <= RAD_W'(r_a_r) * RAD_W'(r_r2);
            r_prod_l     <= RAD_W'(r_a_l) * RAD_W'(r_r2);

            r_msq[0].action  <= r_m3.action;
            r_msq[0].forward <= r_m3.forward;
            for (int i = 1; i < ROOT_W; i++) begin
                r_msq[i].action  <= r_msq[i-1].action;
                r_msq[i].forward <= r_msq[i-1].forward;
            end

            r_md.action  <= r_msq[ROOT_W-1].action;
            r_md.forward <= r_msq[ROOT_W-1].forward;
            r_root_r     <= root_r;
            r_root_l     <= root_l;
            r_p_r        <= PROD_W'(root_r) * PROD_W'(DUTY_RECIP);
            r_p_l        <= PROD_W'(root_l) * PROD_W'(DUTY_RECIP);
            r_sat_r      <= (root_r >= SAT_ROOT);
            r_sat_l      <= (root_l >= SAT_ROOT);

            // stop and hold carry zero duties and no direction
            r_out_action <= r_md.action;
            r_out_dl     <= (r_md.action == ACT_DRIVE) ? duty_l : '0;
            r_out_dr     <= (r_md.action == ACT_DRIVE) ? duty_r : '0;
            r_out_fwd    <= (r_md.action == ACT_DRIVE) && r_md.forward;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.action     = r_out_action;
    assign o_out.duty_left  = r_out_dl;
    assign o_out.duty_right = r_out_dr;
    assign o_out.forward    = r_out_fwd;

endmodule

/* rtl/joystick_differential_drive_mixer.sv */
// Joystick differential drive mixer: an item is accepted into a short queue, then
// passes the read register, squares, sums, radicands, the 16-stage square root pipeline,
// divide and output registers; one item per cycle is sustained while the output is taken.
// A stalled output freezes the back pipeline; input keeps flowing until the queue fills.
// Synchronous active-low reset empties the queue and clears all valid bits.
// Depends on jddm_pkg, jddm_in_if, jddm_out_if, jddm_front, jddm_fifo, jddm_back.
`timescale 1ns / 1ps

module joystick_differential_drive_mixer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jddm_in_if.sink    i_in,
    jddm_out_if.source o_out
);
    import jddm_pkg::*;

    logic  queue_full;
    logic  wr_en;
    t_item wr_item;
    logic  ce;
    logic  rd_valid;
    t_item rd_item;

    jddm_front u_front (
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .o_wr_en      (wr_en),
        .o_wr_item    (wr_item)
    );

    jddm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_item  (wr_item),
        .o_full     (queue_full),
        .i_ce       (ce),
        .o_rd_valid (rd_valid),
        .o_rd_item  (rd_item)
    );

    jddm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rd_valid),
        .i_item  (rd_item),
        .o_ce    (ce),
        .o_out   (o_out)
    );

endmodule
